FILE: rtl/hs3d_pkg.sv
// Shared types and constants for the 3D heat stencil core.
// Used by every module of the block except hs3d_ram; depends on nothing.
package hs3d_pkg;

  localparam int MAX_EDGE  = 32;
  localparam int EDGE_BITS = $clog2(MAX_EDGE);
  localparam int DIM_BITS  = 6;
  localparam int ADDR_BITS = 3 * EDGE_BITS;
  localparam int CELLS     = MAX_EDGE * MAX_EDGE * MAX_EDGE;
  localparam int TEMP_BITS = 24;
  localparam int FRAC_BITS = 15;
  localparam int SUM_BITS  = TEMP_BITS + 3;
  localparam int STEP_BITS = 16;
  localparam int COEF      = ((1 << FRAC_BITS) + 5) / 10;
  localparam int COEF_BITS = FRAC_BITS - 2;
  localparam int TAPS      = 7;
  localparam int TAP_BITS  = 3;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HEIGHT  = 3'd0,
    REG_WIDTH   = 3'd1,
    REG_DEPTH   = 3'd2,
    REG_SRC_ROW = 3'd3,
    REG_SRC_COL = 3'd4,
    REG_SRC_LAY = 3'd5,
    REG_AMBIENT = 3'd6,
    REG_SOURCE  = 3'd7
  } cfg_reg_t;

  localparam logic CMD_RUN  = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam logic ANS_DONE = 1'b0;
  localparam logic ANS_CELL = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [STEP_BITS-1:0] step_count;
    logic [4:0]           cell_row;
    logic [4:0]           cell_col;
    logic [4:0]           cell_layer;
  } in_t;

  typedef struct packed {
    logic                 answer_kind;
    logic [TEMP_BITS-1:0] temperature;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic                capture;
    logic                clr_pos;
    logic                adv_pos;
    logic                init_we;
    logic                gather;
    logic [TAP_BITS-1:0] tap;
    logic                calc_diff;
    logic                calc_scale;
    logic                step_we;
    logic                flip;
    logic                rd_cell;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic                 last_cell;
    logic [TEMP_BITS-1:0] read_value;
  } dp_stat_t;

endpackage

FILE: rtl/heat_stencil_3d_jacobi_core.sv
// Top level of the 3D seven-point heat stencil core.
// Input, output and configuration channels use valid/ready transfers.
// A run command (cmd 0) fills the configured grid with the ambient
// temperature, sets the source cell, then performs step_count Jacobi
// steps and answers with a done result carrying temperature zero.
// A read command (cmd 1) answers with one cell of the present grid;
// coordinates beyond the configured size answer zero.
// Initialisation writes every configured cell in turn; each step then
// handles one cell at a time (seven taps read one at a time through the
// single read port of the current grid RAM, then difference, scale and
// write back). A read passes through issue and wait states before it answers.
// One item is in work at a time; in_ready is high only when idle.
// The result sits in an output register; if the receiver stalls the block
// finishes its work and then holds until the result transfer completes.
// Reset (rst, synchronous) restores register defaults and selects the
// first buffer; grid contents stay undefined until a run writes them.
// Configuration writes are taken at any time and must arrive while idle.
module heat_stencil_3d_jacobi_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  hs3d_pkg::in_t                     in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output hs3d_pkg::out_t                    out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hs3d_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [hs3d_pkg::TEMP_BITS-1:0]    cfg_data
);

  hs3d_pkg::dp_cmd_t  cmd;
  hs3d_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  hs3d_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out),
    .cmd(cmd), .stat(stat)
  );

  hs3d_dpath u_dpath (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_item(in), .cmd(cmd), .stat(stat)
  );

endmodule

FILE: rtl/hs3d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module hs3d_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/hs3d_dpath.sv
// Datapath: configuration registers, sweep counters, the two grid buffers
// and the stencil arithmetic. Depends on hs3d_pkg and hs3d_ram.
module hs3d_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hs3d_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [hs3d_pkg::TEMP_BITS-1:0]      cfg_data,
  input  hs3d_pkg::in_t                       in_item,
  input  hs3d_pkg::dp_cmd_t                   cmd,
  output hs3d_pkg::dp_stat_t                  stat
);

  localparam int EB = hs3d_pkg::EDGE_BITS;
  localparam int DB = hs3d_pkg::DIM_BITS;
  localparam int TB = hs3d_pkg::TEMP_BITS;
  localparam int SB = hs3d_pkg::SUM_BITS;
  localparam int AB = hs3d_pkg::ADDR_BITS;
  localparam int FB = hs3d_pkg::FRAC_BITS;
  localparam int HB = SB - FB;

  logic [DB-1:0] height, width, depth;
  logic [EB-1:0] src_row, src_col, src_lay;
  logic [TB-1:0] ambient, source;

  always_ff @(posedge clk) begin
    if (rst) begin
      height  <= DB'(hs3d_pkg::MAX_EDGE);
      width   <= DB'(hs3d_pkg::MAX_EDGE);
      depth   <= DB'(hs3d_pkg::MAX_EDGE);
      src_row <= EB'(16);
      src_col <= EB'(16);
      src_lay <= EB'(16);
      ambient <= TB'(8945664);
      source  <= TB'(10911744);
    end else if (cfg_we) begin
      case (hs3d_pkg::cfg_reg_t'(cfg_index))
        hs3d_pkg::REG_HEIGHT:  height  <= cfg_data[DB-1:0];
        hs3d_pkg::REG_WIDTH:   width   <= cfg_data[DB-1:0];
        hs3d_pkg::REG_DEPTH:   depth   <= cfg_data[DB-1:0];
        hs3d_pkg::REG_SRC_ROW: src_row <= cfg_data[EB-1:0];
        hs3d_pkg::REG_SRC_COL: src_col <= cfg_data[EB-1:0];
        hs3d_pkg::REG_SRC_LAY: src_lay <= cfg_data[EB-1:0];
        hs3d_pkg::REG_AMBIENT: ambient <= cfg_data;
        hs3d_pkg::REG_SOURCE:  source  <= cfg_data;
        default: ;
      endcase
    end
  end

  // last index in use on each axis; zero means one, oversize means full edge
  function automatic logic [EB-1:0] last_idx(input logic [DB-1:0] v);
    if (v == '0) return '0;
    if (v > DB'(hs3d_pkg::MAX_EDGE)) return EB'(hs3d_pkg::MAX_EDGE - 1);
    return EB'(v - DB'(1));
  endfunction

  logic [EB-1:0] lr, lc, ll;
  assign lr = last_idx(height);
  assign lc = last_idx(width);
  assign ll = last_idx(depth);

  logic [EB-1:0] r, c, l;
  logic          last_cell, is_src;
  assign last_cell = (r == lr) && (c == lc) && (l == ll);
  assign is_src    = (r == src_row) && (c == src_col) && (l == src_lay);

  always_ff @(posedge clk) begin
    if (cmd.clr_pos) begin
      r <= '0;
      c <= '0;
      l <= '0;
    end else if (cmd.adv_pos) begin
      if (l != ll) begin
        l <= l + EB'(1);
      end else begin
        l <= '0;
        if (c != lc) begin
          c <= c + EB'(1);
        end else begin
          c <= '0;
          r <= r + EB'(1);
        end
      end
    end
  end

  // read request coordinates
  logic [EB-1:0] q_row, q_col, q_lay;
  logic          q_in_range;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_row <= in_item.cell_row;
      q_col <= in_item.cell_col;
      q_lay <= in_item.cell_layer;
    end
  end
  assign q_in_range = (q_row <= lr) && (q_col <= lc) && (q_lay <= ll);

  // neighbour address; a missing neighbour reads the centre instead
  logic [AB-1:0] centre, raddr;
  assign centre = {r, c, l};

  always_comb begin
    raddr = centre;
    if (cmd.rd_cell) begin
      raddr = {q_row, q_col, q_lay};
    end else begin
      case (cmd.tap)
        3'd1: if (c != '0) raddr = {r, c - EB'(1), l};
        3'd2: if (c != lc) raddr = {r, c + EB'(1), l};
        3'd3: if (r != '0) raddr = {r - EB'(1), c, l};
        3'd4: if (r != lr) raddr = {r + EB'(1), c, l};
        3'd5: if (l != '0) raddr = {r, c, l - EB'(1)};
        3'd6: if (l != ll) raddr = {r, c, l + EB'(1)};
        default: raddr = centre;
      endcase
    end
  end

  logic          cur_sel;
  logic [TB-1:0] a_q, b_q, rd_cur, wdata;
  logic          we_a, we_b;
  logic [TB-1:0] new_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_sel <= 1'b0;
    end else if (cmd.flip) begin
      cur_sel <= ~cur_sel;
    end
  end

  assign rd_cur = cur_sel ? b_q : a_q;
  assign we_a   = (cmd.init_we && !cur_sel) || (cmd.step_we && cur_sel);
  assign we_b   = (cmd.init_we && cur_sel) || (cmd.step_we && !cur_sel);
  assign wdata  = cmd.init_we ? (is_src ? source : ambient) : new_val;

  hs3d_ram #(.WIDTH(TB), .DEPTH(hs3d_pkg::CELLS)) u_grid_a (
    .clk(clk), .we(we_a), .waddr(centre), .wdata(wdata), .raddr(raddr), .rdata(a_q)
  );

  hs3d_ram #(.WIDTH(TB), .DEPTH(hs3d_pkg::CELLS)) u_grid_b (
    .clk(clk), .we(we_b), .waddr(centre), .wdata(wdata), .raddr(raddr), .rdata(b_q)
  );

  // gather: data of tap k-1 arrives while tap k is issued
  logic [TB-1:0]       tc;
  logic [SB-1:0]       sum;
  logic                neg;
  logic [SB-1:0]       mag;
  logic [TB-1:0]       nv;
  logic signed [SB:0]  diff;
  logic [SB+1:0]       six_tc;
  logic [TB-1:0]       new_val_c;

  assign six_tc = (SB+2)'(tc) * (SB+2)'(6);
  assign diff   = $signed({1'b0, sum}) - $signed(six_tc[SB:0]);

  always_ff @(posedge clk) begin
    if (cmd.gather) begin
      if (cmd.tap == 3'd1) begin
        tc  <= rd_cur;
        sum <= '0;
      end else if (cmd.tap != 3'd0) begin
        sum <= sum + SB'(rd_cur);
      end
    end
    if (cmd.calc_diff) begin
      neg <= diff[SB];
      mag <= diff[SB] ? SB'(-diff) : SB'(diff);
    end
    if (cmd.calc_scale) begin
      nv <= new_val_c;
    end
  end

  // round(mag * COEF / 2^FRAC), halves up, then apply sign and saturate
  logic [HB-1:0]      hi;
  logic [FB-1:0]      lo;
  logic [TB+1:0]      hi_p;
  logic [FB+13:0]     lo_p;
  logic [TB+1:0]      scaled;
  logic signed [TB+2:0] sum_nv;

  assign hi     = mag[SB-1:FB];
  assign lo     = mag[FB-1:0];
  assign hi_p   = (TB+2)'(hi) * (TB+2)'(hs3d_pkg::COEF);
  assign lo_p   = (FB+14)'(lo) * (FB+14)'(hs3d_pkg::COEF) + (FB+14)'(1 << (FB-1));
  assign scaled = hi_p + (TB+2)'(lo_p >> FB);
  assign sum_nv = neg ? $signed({3'b000, tc}) - $signed({1'b0, scaled})
                      : $signed({3'b000, tc}) + $signed({1'b0, scaled});

  always_comb begin
    if (sum_nv < 0) begin
      new_val_c = '0;
    end else if (sum_nv > $signed({3'b000, {TB{1'b1}}})) begin
      new_val_c = '1;
    end else begin
      new_val_c = sum_nv[TB-1:0];
    end
  end

  assign new_val = is_src ? tc : nv;

  assign stat.last_cell  = last_cell;
  assign stat.read_value = q_in_range ? rd_cur : '0;

endmodule

FILE: rtl/hs3d_ctrl.sv
// Controller: sequences initialisation, stencil sweeps and cell reads,
// and holds the result register. Depends on hs3d_pkg.
module hs3d_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hs3d_pkg::in_t       in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output hs3d_pkg::out_t      out_item,
  output hs3d_pkg::dp_cmd_t   cmd,
  input  hs3d_pkg::dp_stat_t  stat
);

  typedef enum logic [3:0] {
    IDLE, INIT, GATHER, DIFF, SCALE, WRITE, RD_ISSUE, RD_WAIT, FINISH
  } state_t;

  state_t                         state;
  logic                           is_read;
  logic [hs3d_pkg::STEP_BITS-1:0] steps_left;
  logic [hs3d_pkg::TAP_BITS-1:0]  tap;
  logic                           out_free;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.tap        = tap;
    cmd.capture    = (state == IDLE) && in_valid;
    cmd.clr_pos    = (state == IDLE)
                  || ((state == INIT) && stat.last_cell)
                  || ((state == WRITE) && stat.last_cell);
    cmd.init_we    = (state == INIT);
    cmd.adv_pos    = ((state == INIT) || (state == WRITE)) && !stat.last_cell;
    cmd.gather     = (state == GATHER);
    cmd.calc_diff  = (state == DIFF);
    cmd.calc_scale = (state == SCALE);
    cmd.step_we    = (state == WRITE);
    cmd.flip       = (state == WRITE) && stat.last_cell;
    cmd.rd_cell    = (state == RD_ISSUE) || (state == RD_WAIT)
                  || ((state == FINISH) && is_read);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      is_read   <= 1'b0;
      tap       <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          tap <= '0;
          if (in_valid) begin
            is_read    <= (in_item.cmd == hs3d_pkg::CMD_READ);
            steps_left <= in_item.step_count;
            state      <= (in_item.cmd == hs3d_pkg::CMD_READ) ? RD_ISSUE : INIT;
          end
        end
        INIT: begin
          if (stat.last_cell) begin
            tap   <= '0;
            state <= (steps_left == '0) ? FINISH : GATHER;
          end
        end
        GATHER: begin
          if (tap == hs3d_pkg::TAP_BITS'(hs3d_pkg::TAPS)) begin
            state <= DIFF;
          end else begin
            tap <= tap + hs3d_pkg::TAP_BITS'(1);
          end
        end
        DIFF:  state <= SCALE;
        SCALE: state <= WRITE;
        WRITE: begin
          tap <= '0;
          if (stat.last_cell) begin
            steps_left <= steps_left - hs3d_pkg::STEP_BITS'(1);
            state <= (steps_left == hs3d_pkg::STEP_BITS'(1)) ? FINISH : GATHER;
          end else begin
            state <= GATHER;
          end
        end
        RD_ISSUE: state <= RD_WAIT;
        RD_WAIT:  state <= FINISH;
        FINISH: begin
          // hold until the result slot is free
          if (out_free) begin
            out_valid            <= 1'b1;
            out_item.answer_kind <= is_read ? hs3d_pkg::ANS_CELL : hs3d_pkg::ANS_DONE;
            out_item.temperature <= is_read ? stat.read_value : '0;
            state                <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a new item while busy");

  a_flip_with_steps: assert property (@(posedge clk) disable iff (rst)
    cmd.flip |-> (steps_left != '0))
    else $error("buffer flip with no step outstanding");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == FINISH))
    else $error("result raised outside the finish state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("pending result dropped");

endmodule

FILE: bench/tb_heat_stencil_3d_jacobi_core.sv
// Testbench for heat_stencil_3d_jacobi_core: directed runs and reads, then random phases.
// A scoreboard class predicts each answer from its own copy of both grid buffers.
// Depends on rtl/hs3d_pkg.sv and the core itself.
`timescale 1ns / 100ps

module tb_heat_stencil_3d_jacobi_core;

  localparam int TW    = hs3d_pkg::TEMP_BITS;
  localparam int NCELL = hs3d_pkg::CELLS;
  localparam int EDGE  = hs3d_pkg::MAX_EDGE;
  localparam longint unsigned T_MAX = (64'd1 << hs3d_pkg::TEMP_BITS) - 1;
  localparam longint unsigned ONE_Q = 64'd1 << hs3d_pkg::FRAC_BITS;

  class heat_scoreboard;
    logic [TW-1:0] grid [2][NCELL];
    bit written [2][NCELL];
    bit sel;
    int unsigned dim_h, dim_w, dim_d, src_r, src_c, src_l;
    longint unsigned ambient, source;
    hs3d_pkg::out_t answers [$];
    int errors;

    function void clear();
      sel = 0;
      dim_h = 32; dim_w = 32; dim_d = 32;
      src_r = 16; src_c = 16; src_l = 16;
      ambient = 8945664; source = 10911744;
      errors = 0;
      for (int b = 0; b < 2; b++)
        for (int i = 0; i < NCELL; i++) written[b][i] = 0;
    endfunction

    function void set_reg(hs3d_pkg::cfg_reg_t idx, logic [TW-1:0] val);
      case (idx)
        hs3d_pkg::REG_HEIGHT:  dim_h = val & 63;
        hs3d_pkg::REG_WIDTH:   dim_w = val & 63;
        hs3d_pkg::REG_DEPTH:   dim_d = val & 63;
        hs3d_pkg::REG_SRC_ROW: src_r = val & 31;
        hs3d_pkg::REG_SRC_COL: src_c = val & 31;
        hs3d_pkg::REG_SRC_LAY: src_l = val & 31;
        hs3d_pkg::REG_AMBIENT: ambient = val;
        hs3d_pkg::REG_SOURCE:  source = val;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(int unsigned v);
      if (v == 0) return 1;
      if (v > EDGE) return EDGE;
      return v;
    endfunction

    function int cell_at(int unsigned r, int unsigned c, int unsigned l);
      return (r * EDGE + c) * EDGE + l;
    endfunction

    // round(m * COEF / 2^FRAC_BITS), halves up
    function longint unsigned scaled(longint unsigned m);
      longint unsigned hi, lo;
      hi = m >> hs3d_pkg::FRAC_BITS;
      lo = m & (ONE_Q - 1);
      return hi * hs3d_pkg::COEF
           + ((lo * hs3d_pkg::COEF + (ONE_Q >> 1)) >> hs3d_pkg::FRAC_BITS);
    endfunction

    function void jacobi_sweep(int unsigned h, int unsigned w, int unsigned d);
      int a;
      longint tc, sum, diff, nv;
      bit cur, nxt;
      cur = sel;
      nxt = !sel;
      for (int unsigned r = 0; r < h; r++)
        for (int unsigned c = 0; c < w; c++)
          for (int unsigned l = 0; l < d; l++) begin
            a = cell_at(r, c, l);
            tc = grid[cur][a];
            written[nxt][a] = 1;
            if (r == src_r && c == src_c && l == src_l) begin
              grid[nxt][a] = grid[cur][a];
              continue;
            end
            sum  = (c != 0)     ? grid[cur][cell_at(r, c - 1, l)] : tc;
            sum += (c + 1 < w)  ? grid[cur][cell_at(r, c + 1, l)] : tc;
            sum += (r != 0)     ? grid[cur][cell_at(r - 1, c, l)] : tc;
            sum += (r + 1 < h)  ? grid[cur][cell_at(r + 1, c, l)] : tc;
            sum += (l != 0)     ? grid[cur][cell_at(r, c, l - 1)] : tc;
            sum += (l + 1 < d)  ? grid[cur][cell_at(r, c, l + 1)] : tc;
            diff = sum - 6 * tc;
            if (diff < 0) nv = tc - longint'(scaled(-diff));
            else nv = tc + longint'(scaled(diff));
            if (nv < 0) nv = 0;
            if (nv > longint'(T_MAX)) nv = T_MAX;
            grid[nxt][a] = TW'(nv);
          end
      sel = !sel;
    endfunction

    // true unless the read would hit an entry no run has written
    function bit safe_read(int unsigned r, int unsigned c, int unsigned l);
      if (r >= clamp_dim(dim_h) || c >= clamp_dim(dim_w) || l >= clamp_dim(dim_d))
        return 1;
      return written[sel][cell_at(r, c, l)];
    endfunction

    function void note_item(hs3d_pkg::in_t it);
      int unsigned h, w, d;
      hs3d_pkg::out_t exp_ans;
      h = clamp_dim(dim_h);
      w = clamp_dim(dim_w);
      d = clamp_dim(dim_d);
      if (it.cmd == hs3d_pkg::CMD_RUN) begin
        for (int unsigned r = 0; r < h; r++)
          for (int unsigned c = 0; c < w; c++)
            for (int unsigned l = 0; l < d; l++) begin
              grid[sel][cell_at(r, c, l)] =
                TW'((r == src_r && c == src_c && l == src_l) ? source : ambient);
              written[sel][cell_at(r, c, l)] = 1;
            end
        for (int t = 0; t < it.step_count; t++) jacobi_sweep(h, w, d);
        exp_ans.answer_kind = hs3d_pkg::ANS_DONE;
        exp_ans.temperature = '0;
      end else begin
        exp_ans.answer_kind = hs3d_pkg::ANS_CELL;
        exp_ans.temperature = '0;
        if (it.cell_row < h && it.cell_col < w && it.cell_layer < d)
          exp_ans.temperature = grid[sel][cell_at(it.cell_row, it.cell_col, it.cell_layer)];
      end
      answers.push_back(exp_ans);
    endfunction

    function void check_answer(hs3d_pkg::out_t got);
      hs3d_pkg::out_t want;
      if (answers.size() == 0) begin
        $error("unexpected answer kind=%0d temperature=%0h", got.answer_kind,
               got.temperature);
        errors++;
        return;
      end
      want = answers.pop_front();
      if (got.answer_kind !== want.answer_kind) begin
        $error("answer_kind: expected %0d, got %0d", want.answer_kind, got.answer_kind);
        errors++;
      end
      if (got.temperature !== want.temperature) begin
        $error("temperature: expected %0h, got %0h", want.temperature, got.temperature);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  hs3d_pkg::in_t  in_item = '0;
  logic out_valid;
  logic out_ready = 0;
  hs3d_pkg::out_t out_item;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [hs3d_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [TW-1:0] cfg_data = '0;

  heat_scoreboard board = new;
  bit quiet = 0;
  int sent = 0;

  heat_stencil_3d_jacobi_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(negedge clk) out_ready <= quiet || ($urandom_range(99) >= 27);

  always @(posedge clk) if (!rst && out_valid && out_ready) board.check_answer(out_item);

  task automatic drop_input();
    @(negedge clk) in_valid <= 0;
  endtask

  task automatic send_item(hs3d_pkg::in_t it);
    if (!quiet && $urandom_range(99) < 27) begin
      drop_input();
      repeat ($urandom_range(4)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    board.note_item(it);
    sent++;
  endtask

  task automatic drain();
    drop_input();
    while (board.answers.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(hs3d_pkg::cfg_reg_t idx, logic [TW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
  endtask

  // wait for idle, then load every register
  task automatic load_setup(int h, int w, int d, int sr, int sc, int sl,
                            logic [TW-1:0] amb, logic [TW-1:0] srct);
    drain();
    write_reg(hs3d_pkg::REG_HEIGHT, TW'(h));
    write_reg(hs3d_pkg::REG_WIDTH, TW'(w));
    write_reg(hs3d_pkg::REG_DEPTH, TW'(d));
    write_reg(hs3d_pkg::REG_SRC_ROW, TW'(sr));
    write_reg(hs3d_pkg::REG_SRC_COL, TW'(sc));
    write_reg(hs3d_pkg::REG_SRC_LAY, TW'(sl));
    write_reg(hs3d_pkg::REG_AMBIENT, amb);
    write_reg(hs3d_pkg::REG_SOURCE, srct);
    @(negedge clk) cfg_valid <= 0;
  endtask

  task automatic run_grid(int steps);
    hs3d_pkg::in_t it;
    it.cmd = hs3d_pkg::CMD_RUN;
    it.step_count = 16'(steps);
    it.cell_row = 5'($urandom);
    it.cell_col = 5'($urandom);
    it.cell_layer = 5'($urandom);
    send_item(it);
  endtask

  task automatic read_cell(int r, int c, int l);
    hs3d_pkg::in_t it;
    it.cmd = hs3d_pkg::CMD_READ;
    it.step_count = 16'($urandom);
    it.cell_row = 5'(r);
    it.cell_col = 5'(c);
    it.cell_layer = 5'(l);
    // never touch an entry that no run has filled
    if (!board.safe_read(r, c, l)) begin
      it.cell_row = '0; it.cell_col = '0; it.cell_layer = '0;
    end
    send_item(it);
  endtask

  initial begin
    int h, w, d, lim;
    board.clear();
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 0;

    // single cell, source on it
    load_setup(1, 1, 1, 0, 0, 0, 24'h000000, 24'hFFFFFF);
    run_grid(0);
    read_cell(0, 0, 0);
    read_cell(31, 31, 31);
    // full grid, initialise only
    load_setup(32, 32, 32, 31, 31, 31, 24'hFFFFFF, 24'h000000);
    run_grid(0);
    read_cell(31, 31, 31);
    read_cell(0, 0, 0);
    read_cell(31, 0, 17);
    // zero height, oversized width
    load_setup(0, 63, 2, 20, 1, 0, 24'h400000, 24'hFFFFFF);
    run_grid(3);
    read_cell(0, 19, 0);
    read_cell(0, 20, 1);
    read_cell(0, 31, 1);
    read_cell(1, 0, 0);
    // source outside the grid
    load_setup(3, 3, 3, 5, 1, 1, 24'hABCDEF, 24'h000000);
    run_grid(2);
    read_cell(1, 1, 1);
    read_cell(2, 2, 2);
    read_cell(0, 3, 0);
    // hot source into zero ambient
    load_setup(2, 3, 2, 0, 1, 1, 24'h000000, 24'hFFFFFF);
    run_grid(4);
    read_cell(1, 2, 0);
    read_cell(0, 1, 1);
    // longest run on a single cell
    load_setup(1, 1, 1, 9, 9, 9, 24'h123456, 24'h654321);
    run_grid(65535);
    read_cell(0, 0, 0);

    while (sent < 100) begin
      lim = ($urandom_range(9) == 0) ? 2 : 4;
      h = $urandom_range(lim);
      w = $urandom_range(lim);
      d = $urandom_range(lim);
      if ($urandom_range(9) == 0) begin
        h = $urandom_range(20, 63);
        w = 1;
        d = 1;
      end
      load_setup(h, w, d, $urandom_range(5), $urandom_range(5), $urandom_range(5),
                 TW'($urandom), TW'($urandom));
      if ($urandom_range(3) == 0) read_cell($urandom_range(6), $urandom_range(6),
                                            $urandom_range(6));
      run_grid($urandom_range(4));
      repeat ($urandom_range(2, 7)) begin
        quiet = (sent >= 60 && sent < 90);
        if ($urandom_range(4) == 0)
          read_cell($urandom_range(31), $urandom_range(31), $urandom_range(31));
        else
          read_cell($urandom_range(5), $urandom_range(5), $urandom_range(5));
      end
    end

    drop_input();
    while (board.answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.answers.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #40000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
